// ----- rtl/core/flow_sensor_frame_checker_unit_assert.svh -----
// assertion macros used by the checker file
`ifndef FLOW_SENSOR_FRAME_CHECKER_UNIT_ASSERT_SVH
`define FLOW_SENSOR_FRAME_CHECKER_UNIT_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define FSFC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("frame checker assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define FSFC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("frame checker assertion failed");

`endif

// ----- rtl/core/fsfc_pkg.sv -----
package fsfc_pkg;

   // default number of fraction bits of the scaled results
   localparam int FRACTION_BITS_DEFAULT = 8;

   // field widths
   localparam int RAW_W       = 16;
   localparam int FLOW_W      = 24;
   localparam int TEMP_W      = 17;
   localparam int FLAG_W      = 16;
   localparam int INDEX_W     = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 16;

   // check byte polynomial and start value
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_TOP  = 8'h80;

   // fixed temperature divisor and register reset values
   localparam logic [15:0] TEMP_DIVISOR = 16'd200;
   localparam logic [15:0] SCALE_RESET  = 16'd500;
   localparam logic [1:0]  WORDS_RESET  = 2'd3;

   // 200 is 8 x 25: drop three bits, then multiply by 2^32 / 25 rounded up,
   // exact for every dividend below 2^30
   localparam int          TEMP_SHIFT  = 3;
   localparam int          RECIP_SHIFT = 32;
   localparam logic [31:0] TEMP_RECIP  = 32'd171798692;

   // result status codes
   typedef enum logic [1:0] {
      STATUS_OK            = 2'd0,
      STATUS_CRC_ERROR     = 2'd1,
      STATUS_NOT_MEASURING = 2'd2
   } status_type;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_SCALE_DIVISOR     = 2'd0,
      REG_FRAME_WORD_COUNT  = 2'd1,
      REG_MEASURING_ENABLED = 2'd2
   } csr_index_type;

   // controller to datapath commands
   typedef struct packed {
      logic                crc_init;
      logic                crc_update;
      logic                crc_reset;
      logic                capture_high;
      logic                capture_low;
      logic                store_flow;
      logic                store_temp;
      logic                div_start;
      logic                temp_mul;
      logic                flow_capture;
      logic                temp_capture;
      logic                rsp_load;
      status_type          rsp_code;
      logic [INDEX_W-1:0]  rsp_index;
      logic                rsp_temp_en;
      logic                rsp_flag_en;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic       crc_match;
      logic       div_done;
      logic       rsp_full;
      logic       measuring_enabled;
      logic [1:0] word_count;
   } status_word_type;

   // one byte through the crc, msb first, eight shift steps
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
      logic [7:0] c;
      c = crc_in ^ data;
      for (int i = 0; i < 8; i++) begin
         if ((c & CRC_TOP) != 8'd0) begin
            c = (c << 1) ^ CRC_POLY;
         end else begin
            c = c << 1;
         end
      end
      return c;
   endfunction

endpackage

// ----- rtl/core/fsfc_div.sv -----
module fsfc_div #(
   parameter int DIVIDEND_W = fsfc_pkg::RAW_W + fsfc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [15:0]           divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [15:0]           rem_ff, rem_in;
   logic [15:0]           divisor_ff, divisor_in;
   logic [DIVIDEND_W-1:0] quot_ff, quot_in;
   logic [16:0]           trial;
   logic [16:0]           diff;
   logic                  fits;

   // one restoring step: bring down the next dividend bit and try a subtract
   assign trial = {rem_ff, quot_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, divisor_ff};
   assign fits  = trial >= {1'b0, divisor_ff};

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      count_in   = count_ff;
      rem_in     = rem_ff;
      quot_in    = quot_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         rem_in     = '0;
         quot_in    = dividend;
         divisor_in = divisor;
      end else if (busy_ff) begin
         rem_in   = fits ? diff[15:0] : trial[15:0];
         quot_in  = {quot_ff[DIVIDEND_W-2:0], fits};
         count_in = count_ff + CNT_W'(1);
         if (count_ff == CNT_W'(DIVIDEND_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quot_ff    <= quot_in;
      divisor_ff <= divisor_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

// ----- rtl/core/fsfc_ctrl.sv -----
module fsfc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_frame_start,
   output logic                      req_stall,
   input  logic                      rsp_stall,
   input  fsfc_pkg::status_word_type status,
   output fsfc_pkg::cmd_type         cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FLOW_GO,
      ST_FLOW_WAIT,
      ST_TEMP_MUL,
      ST_TEMP_SAT,
      ST_EMIT
   } state_type;

   state_type   state_ff, state_in;
   logic [1:0]  byte_in_word_ff, byte_in_word_in;
   logic [1:0]  word_index_ff, word_index_in;
   logic        frame_aborted_ff, frame_aborted_in;
   logic [1:0]  byte_cur;
   logic [1:0]  word_cur;
   logic        aborted_cur;
   logic [1:0]  words_eff;
   logic        accept;

   // a result slot frees up in the cycle its beat is taken
   assign req_stall = (state_ff != ST_IDLE) || (status.rsp_full && rsp_stall);
   assign accept    = req_valid && !req_stall;

   // a new frame restarts the word and clears the abort
   assign byte_cur    = req_frame_start ? 2'd0 : byte_in_word_ff;
   assign word_cur    = req_frame_start ? 2'd0 : word_index_ff;
   assign aborted_cur = req_frame_start ? 1'b0 : frame_aborted_ff;
   assign words_eff   = (status.word_count == 2'd0) ? 2'd1 : status.word_count;

   always_comb begin
      cmd              = '0;
      state_in         = state_ff;
      byte_in_word_in  = byte_in_word_ff;
      word_index_in    = word_index_ff;
      frame_aborted_in = frame_aborted_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.crc_init     = req_frame_start;
               byte_in_word_in  = byte_cur;
               word_index_in    = word_cur;
               frame_aborted_in = aborted_cur;
               if (!aborted_cur) begin
                  if (!status.measuring_enabled) begin
                     // byte while measurement is off
                     frame_aborted_in = 1'b1;
                     cmd.rsp_load     = 1'b1;
                     cmd.rsp_code     = fsfc_pkg::STATUS_NOT_MEASURING;
                  end else if (byte_cur == 2'd0) begin
                     cmd.capture_high = 1'b1;
                     cmd.crc_update   = 1'b1;
                     byte_in_word_in  = 2'd1;
                  end else if (byte_cur == 2'd1) begin
                     cmd.capture_low  = 1'b1;
                     cmd.crc_update   = 1'b1;
                     byte_in_word_in  = 2'd2;
                  end else if (!status.crc_match) begin
                     // check byte disagrees: report the word and drop the frame
                     frame_aborted_in = 1'b1;
                     cmd.rsp_load     = 1'b1;
                     cmd.rsp_code     = fsfc_pkg::STATUS_CRC_ERROR;
                     cmd.rsp_index    = word_cur;
                  end else begin
                     cmd.store_flow = (word_cur == 2'd0);
                     cmd.store_temp = (word_cur == 2'd1);
                     if ((word_cur + 2'd1) < words_eff) begin
                        word_index_in   = word_cur + 2'd1;
                        byte_in_word_in = 2'd0;
                        cmd.crc_reset   = 1'b1;
                     end else begin
                        frame_aborted_in = 1'b1;
                        state_in         = ST_FLOW_GO;
                     end
                  end
               end
            end
         end
         ST_FLOW_GO: begin
            cmd.div_start = 1'b1;
            state_in      = ST_FLOW_WAIT;
         end
         ST_FLOW_WAIT: begin
            if (status.div_done) begin
               cmd.flow_capture = 1'b1;
               state_in         = (words_eff >= 2'd2) ? ST_TEMP_MUL : ST_EMIT;
            end
         end
         ST_TEMP_MUL: begin
            cmd.temp_mul = 1'b1;
            state_in     = ST_TEMP_SAT;
         end
         ST_TEMP_SAT: begin
            cmd.temp_capture = 1'b1;
            state_in         = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.rsp_load    = 1'b1;
            cmd.rsp_code    = fsfc_pkg::STATUS_OK;
            cmd.rsp_temp_en = (words_eff >= 2'd2);
            cmd.rsp_flag_en = (words_eff == 2'd3);
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and frame position
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         byte_in_word_ff  <= 2'd0;
         word_index_ff    <= 2'd0;
         frame_aborted_ff <= 1'b1;
      end else begin
         state_ff         <= state_in;
         byte_in_word_ff  <= byte_in_word_in;
         word_index_ff    <= word_index_in;
         frame_aborted_ff <= frame_aborted_in;
      end
   end

endmodule

// ----- rtl/core/fsfc_dp.sv -----
module fsfc_dp #(
   parameter int FRACTION_BITS = fsfc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  fsfc_pkg::cmd_type                    cmd,
   output fsfc_pkg::status_word_type            status,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 csr_write_enable,
   input  logic [fsfc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fsfc_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fsfc_pkg::FLOW_W-1:0]   rsp_flow_q8,
   output logic signed [fsfc_pkg::TEMP_W-1:0]   rsp_temperature_q8,
   output logic [fsfc_pkg::FLAG_W-1:0]          rsp_flag_word,
   output logic [1:0]                           rsp_status,
   output logic [fsfc_pkg::INDEX_W-1:0]         rsp_bad_word_index
);

   localparam int DIV_W  = fsfc_pkg::RAW_W + FRACTION_BITS;
   localparam int LW     = DIV_W + fsfc_pkg::FLOW_W + 1;
   localparam int PROD_W = DIV_W + fsfc_pkg::RECIP_SHIFT;

   // configuration
   logic [15:0] scale_ff, scale_in;
   logic [1:0]  words_ff, words_in;
   logic        enable_ff, enable_in;

   // frame registers
   logic [7:0]  crc_ff, crc_in;
   logic [7:0]  high_ff;
   logic [7:0]  low_ff;
   logic [15:0] flow_raw_ff;
   logic [15:0] temp_raw_ff;
   logic [fsfc_pkg::FLOW_W-1:0] flow_q_ff;
   logic [fsfc_pkg::TEMP_W-1:0] temp_q_ff;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [fsfc_pkg::FLOW_W-1:0]     rsp_flow_ff;
   logic [fsfc_pkg::TEMP_W-1:0]     rsp_temp_ff;
   logic [fsfc_pkg::FLAG_W-1:0]     rsp_flag_ff;
   logic [1:0]                      rsp_status_ff;
   logic [fsfc_pkg::INDEX_W-1:0]    rsp_index_ff;

   // flow divider hookup
   logic [15:0]      mag;
   logic [DIV_W-1:0] dividend;
   logic [15:0]      divisor;
   logic             div_done;
   logic [DIV_W-1:0] quotient;

   // temperature reciprocal multiply
   logic [15:0]       temp_mag;
   logic [DIV_W-1:0]  temp_eighth;
   logic [PROD_W-1:0] temp_prod;
   logic [DIV_W-1:0]  temp_quot_ff;

   logic [LW-1:0]    flow_sat;
   logic [LW-1:0]    temp_sat;

   // clamp a magnitude quotient to a signed field and apply the sign
   function automatic logic [LW-1:0] sat_scale(input logic [DIV_W-1:0] q, input logic neg,
                                                input int out_bits);
      logic [LW-1:0] qw;
      logic [LW-1:0] lim;
      qw = LW'(q);
      if (neg) begin
         lim = LW'(1) << (out_bits - 1);
         if (qw > lim) begin
            qw = lim;
         end
         return LW'(0) - qw;
      end
      lim = (LW'(1) << (out_bits - 1)) - LW'(1);
      if (qw > lim) begin
         qw = lim;
      end
      return qw;
   endfunction

   // register writes
   always_comb begin
      scale_in  = scale_ff;
      words_in  = words_ff;
      enable_in = enable_ff;
      if (csr_write_enable) begin
         unique case (fsfc_pkg::csr_index_type'(csr_index))
            fsfc_pkg::REG_SCALE_DIVISOR:     scale_in  = csr_write_data;
            fsfc_pkg::REG_FRAME_WORD_COUNT:  words_in  = csr_write_data[1:0];
            fsfc_pkg::REG_MEASURING_ENABLED: enable_in = csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   // running check byte
   always_comb begin
      crc_in = crc_ff;
      if (cmd.crc_update) begin
         crc_in = fsfc_pkg::crc8_byte(cmd.crc_init ? fsfc_pkg::CRC_INIT : crc_ff,
                                      req_data_byte);
      end else if (cmd.crc_init || cmd.crc_reset) begin
         crc_in = fsfc_pkg::CRC_INIT;
      end
   end

   // flow magnitude shifted up by the fraction bits
   assign mag      = flow_raw_ff[15] ? (~flow_raw_ff + 16'd1) : flow_raw_ff;
   assign dividend = DIV_W'(mag) << FRACTION_BITS;
   assign divisor  = (scale_ff == 16'd0) ? 16'd1 : scale_ff;

   fsfc_div #(
      .DIVIDEND_W (DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (div_done),
      .quotient (quotient)
   );

   // temperature magnitude over 200: drop three bits, then multiply by the reciprocal of 25
   assign temp_mag    = temp_raw_ff[15] ? (~temp_raw_ff + 16'd1) : temp_raw_ff;
   assign temp_eighth = (DIV_W'(temp_mag) << FRACTION_BITS) >> fsfc_pkg::TEMP_SHIFT;
   assign temp_prod   = PROD_W'(temp_eighth) * PROD_W'(fsfc_pkg::TEMP_RECIP);

   assign flow_sat = sat_scale(quotient, flow_raw_ff[15], fsfc_pkg::FLOW_W);
   assign temp_sat = sat_scale(temp_quot_ff, temp_raw_ff[15], fsfc_pkg::TEMP_W);

   // result slot: filled on load, emptied when its beat is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= fsfc_pkg::SCALE_RESET;
         words_ff     <= fsfc_pkg::WORDS_RESET;
         enable_ff    <= 1'b0;
         crc_ff       <= fsfc_pkg::CRC_INIT;
         rsp_valid_ff <= 1'b0;
      end else begin
         scale_ff     <= scale_in;
         words_ff     <= words_in;
         enable_ff    <= enable_in;
         crc_ff       <= crc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture_high) begin
         high_ff <= req_data_byte;
      end
      if (cmd.capture_low) begin
         low_ff <= req_data_byte;
      end
      if (cmd.store_flow) begin
         flow_raw_ff <= {high_ff, low_ff};
      end
      if (cmd.store_temp) begin
         temp_raw_ff <= {high_ff, low_ff};
      end
      if (cmd.temp_mul) begin
         temp_quot_ff <= temp_prod[fsfc_pkg::RECIP_SHIFT +: DIV_W];
      end
      if (cmd.flow_capture) begin
         flow_q_ff <= flow_sat[fsfc_pkg::FLOW_W-1:0];
      end
      if (cmd.temp_capture) begin
         temp_q_ff <= temp_sat[fsfc_pkg::TEMP_W-1:0];
      end
      if (cmd.rsp_load) begin
         rsp_status_ff <= cmd.rsp_code;
         if (cmd.rsp_code == fsfc_pkg::STATUS_OK) begin
            rsp_flow_ff  <= flow_q_ff;
            rsp_temp_ff  <= cmd.rsp_temp_en ? temp_q_ff : '0;
            rsp_flag_ff  <= cmd.rsp_flag_en ? {high_ff, low_ff} : '0;
            rsp_index_ff <= '0;
         end else begin
            rsp_flow_ff  <= '0;
            rsp_temp_ff  <= '0;
            rsp_flag_ff  <= '0;
            rsp_index_ff <= (cmd.rsp_code == fsfc_pkg::STATUS_CRC_ERROR) ? cmd.rsp_index : '0;
         end
      end
   end

   assign status.crc_match         = (crc_ff == req_data_byte);
   assign status.div_done          = div_done;
   assign status.rsp_full          = rsp_valid_ff;
   assign status.measuring_enabled = enable_ff;
   assign status.word_count        = words_ff;

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_flow_q8        = rsp_flow_ff;
   assign rsp_temperature_q8 = rsp_temp_ff;
   assign rsp_flag_word      = rsp_flag_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_bad_word_index = rsp_index_ff;

endmodule

// ----- rtl/core/flow_sensor_frame_checker_unit.sv -----
// Flow sensor frame checker: takes sensor bytes one beat at a time (16-bit words, high byte
// first, each followed by a CRC-8 byte, poly 0x31, start 0xFF) and gives at most one result
// per frame: a CRC error naming the failing word, a not-measuring status, or at frame end the
// flow (raw / scale_divisor) and temperature (raw / 200) in signed fixed point with
// FRACTION_BITS fraction bits, truncated toward zero and saturated, plus the flags word.
// Every byte that does not close a frame is taken without holding off input. The byte that closes
// a good frame holds off input while a restoring divider produces one flow quotient bit per cycle
// and the temperature divide by 200 runs as a constant reciprocal multiply followed by a
// saturation step (both temperature steps are skipped in a one-word frame).
// The result beat is offered in the cycle input is released. While a result waits under
// rsp_stall, input bytes are stalled as well.
// Configuration is written through csr_write_enable / csr_index / csr_write_data.
module flow_sensor_frame_checker_unit #(
   parameter int FRACTION_BITS = fsfc_pkg::FRACTION_BITS_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_frame_start,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [fsfc_pkg::FLOW_W-1:0]   rsp_flow_q8,
   output logic signed [fsfc_pkg::TEMP_W-1:0]   rsp_temperature_q8,
   output logic [fsfc_pkg::FLAG_W-1:0]          rsp_flag_word,
   output logic [1:0]                           rsp_status,
   output logic [fsfc_pkg::INDEX_W-1:0]         rsp_bad_word_index,
   input  logic                                 csr_write_enable,
   input  logic [fsfc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fsfc_pkg::CSR_DATA_W-1:0]      csr_write_data
);

   fsfc_pkg::cmd_type         cmd;
   fsfc_pkg::status_word_type status;

   // frame sequencing
   fsfc_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_frame_start (req_frame_start),
      .req_stall       (req_stall),
      .rsp_stall       (rsp_stall),
      .status          (status),
      .cmd             (cmd)
   );

   // crc, word capture, division and result register
   fsfc_dp #(
      .FRACTION_BITS (FRACTION_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_data_byte      (req_data_byte),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_flow_q8        (rsp_flow_q8),
      .rsp_temperature_q8 (rsp_temperature_q8),
      .rsp_flag_word      (rsp_flag_word),
      .rsp_status         (rsp_status),
      .rsp_bad_word_index (rsp_bad_word_index)
   );

endmodule

// ----- rtl/core/fsfc_checker.sv -----
`include "flow_sensor_frame_checker_unit_assert.svh"

module fsfc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 rsp_valid,
   input logic                                 rsp_stall,
   input logic signed [fsfc_pkg::FLOW_W-1:0]   rsp_flow_q8,
   input logic signed [fsfc_pkg::TEMP_W-1:0]   rsp_temperature_q8,
   input logic [fsfc_pkg::FLAG_W-1:0]          rsp_flag_word,
   input logic [1:0]                           rsp_status,
   input logic [fsfc_pkg::INDEX_W-1:0]         rsp_bad_word_index
);

   // a shown beat carries one of the three defined codes
   `FSFC_ASSERT_NOW(a_status_code, rsp_valid, (rsp_status == fsfc_pkg::STATUS_OK) || (rsp_status == fsfc_pkg::STATUS_CRC_ERROR) || (rsp_status == fsfc_pkg::STATUS_NOT_MEASURING))

   // error beats carry no measurement
   `FSFC_ASSERT_NOW(a_error_fields_clear, rsp_valid && (rsp_status != fsfc_pkg::STATUS_OK), (rsp_flow_q8 == '0) && (rsp_temperature_q8 == '0) && (rsp_flag_word == '0))

   // the failing word index only on crc errors, and never past the third word
   `FSFC_ASSERT_NOW(a_index_meaning, rsp_valid, ((rsp_status == fsfc_pkg::STATUS_CRC_ERROR) || (rsp_bad_word_index == '0)) && (rsp_bad_word_index != 2'd3))

   // a stalled result stays on offer
   `FSFC_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_status))

endmodule

bind flow_sensor_frame_checker_unit fsfc_checker u_fsfc_checker (.*);

// ----- verif/fsfc_reading_checker.sv -----
`timescale 1ns / 100ps

module fsfc_reading_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_frame_start,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic signed [fsfc_pkg::FLOW_W-1:0]   rsp_flow_q8,
   input  logic signed [fsfc_pkg::TEMP_W-1:0]   rsp_temperature_q8,
   input  logic [fsfc_pkg::FLAG_W-1:0]          rsp_flag_word,
   input  logic [1:0]                           rsp_status,
   input  logic [fsfc_pkg::INDEX_W-1:0]         rsp_bad_word_index,
   input  logic                                 csr_write_enable,
   input  logic [fsfc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [fsfc_pkg::CSR_DATA_W-1:0]      csr_write_data,
   output int                                   mismatch_count,
   output int                                   readings_due
);
   import fsfc_pkg::*;

   localparam int FRAC = FRACTION_BITS_DEFAULT;

   // one reading as the block should report it
   typedef struct packed {
      logic signed [FLOW_W-1:0] flow;
      logic signed [TEMP_W-1:0] temp;
      logic [FLAG_W-1:0]        flags;
      status_type               code;
      logic [INDEX_W-1:0]       word;
   } reading_t;

   reading_t awaited_readings [$];

   // register copies
   logic [15:0] flow_scale;
   logic [1:0]  words_per_frame;
   logic        measuring;

   // deframer state
   logic [1:0]  byte_slot;
   logic [1:0]  word_slot;
   logic [7:0]  crc_run;
   logic [7:0]  hi_byte;
   logic [7:0]  lo_byte;
   logic [15:0] flow_raw;
   logic [15:0] temp_raw;
   logic        frame_closed;
   int          faults = 0;

   // msb-first crc-8, one data bit per step
   function automatic logic [7:0] crc_fold(input logic [7:0] crc, input logic [7:0] data);
      logic [7:0] c;
      logic       feedback;
      c = crc;
      for (int i = 7; i >= 0; i--) begin
         feedback = c[7] ^ data[i];
         c = {c[6:0], 1'b0} ^ (feedback ? CRC_POLY : 8'h00);
      end
      return c;
   endfunction

   // signed raw word scaled up by the fraction bits, divided, truncated toward zero, saturated
   function automatic logic [FLOW_W-1:0] scaled_quotient(input logic [15:0] raw,
                                                         input logic [15:0] divisor,
                                                         input int out_bits);
      longint unsigned mag;
      longint unsigned q;
      longint unsigned ceiling;
      mag = raw[15] ? 64'd65536 - {48'd0, raw} : {48'd0, raw};
      q = (mag << FRAC) / ((divisor == 16'd0) ? 64'd1 : {48'd0, divisor});
      ceiling = (64'd1 << (out_bits - 1)) - (raw[15] ? 64'd0 : 64'd1);
      if (q > ceiling) begin
         q = ceiling;
      end
      if (raw[15]) begin
         q = -q;
      end
      return q[FLOW_W-1:0];
   endfunction

   // advance the deframer by one accepted byte, queue the reading it produces
   task automatic absorb_byte(input logic [7:0] b, input logic start);
      reading_t       r;
      logic [1:0]     words;
      logic [FLOW_W-1:0] tq;
      r = '0;
      if (start) begin
         word_slot    = 2'd0;
         byte_slot    = 2'd0;
         crc_run      = CRC_INIT;
         frame_closed = 1'b0;
      end
      if (frame_closed) begin
         // aborted or finished frame: byte ignored
      end else if (!measuring) begin
         frame_closed = 1'b1;
         r.code = STATUS_NOT_MEASURING;
         awaited_readings.push_back(r);
      end else if (byte_slot == 2'd0) begin
         hi_byte   = b;
         crc_run   = crc_fold(crc_run, b);
         byte_slot = 2'd1;
      end else if (byte_slot == 2'd1) begin
         lo_byte   = b;
         crc_run   = crc_fold(crc_run, b);
         byte_slot = 2'd2;
      end else if (crc_run != b) begin
         frame_closed = 1'b1;
         r.code = STATUS_CRC_ERROR;
         r.word = word_slot;
         awaited_readings.push_back(r);
      end else begin
         if (word_slot == 2'd0) begin
            flow_raw = {hi_byte, lo_byte};
         end else if (word_slot == 2'd1) begin
            temp_raw = {hi_byte, lo_byte};
         end
         // a word count of zero means one word
         words = (words_per_frame == 2'd0) ? 2'd1 : words_per_frame;
         if (int'(word_slot) + 1 < int'(words)) begin
            word_slot = word_slot + 2'd1;
            byte_slot = 2'd0;
            crc_run   = CRC_INIT;
         end else begin
            frame_closed = 1'b1;
            r.flow = scaled_quotient(flow_raw, flow_scale, FLOW_W);
            if (words >= 2'd2) begin
               tq = scaled_quotient(temp_raw, TEMP_DIVISOR, TEMP_W);
               r.temp = tq[TEMP_W-1:0];
            end
            if (words >= 2'd3) begin
               r.flags = {hi_byte, lo_byte};
            end
            awaited_readings.push_back(r);
         end
      end
   endtask

   // watch the three ports, predict and compare
   always @(posedge clock) begin
      reading_t want;
      if (reset) begin
         flow_scale      = SCALE_RESET;
         words_per_frame = WORDS_RESET;
         measuring       = 1'b0;
         byte_slot       = 2'd0;
         word_slot       = 2'd0;
         crc_run         = CRC_INIT;
         hi_byte         = 8'd0;
         lo_byte         = 8'd0;
         flow_raw        = 16'd0;
         temp_raw        = 16'd0;
         frame_closed    = 1'b1;
         awaited_readings.delete();
      end else begin
         if (csr_write_enable) begin
            case (csr_index)
               REG_SCALE_DIVISOR:     flow_scale      = csr_write_data[15:0];
               REG_FRAME_WORD_COUNT:  words_per_frame = csr_write_data[1:0];
               REG_MEASURING_ENABLED: measuring       = csr_write_data[0];
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            absorb_byte(req_data_byte, req_frame_start);
         end
         if (rsp_valid && !rsp_stall) begin
            if (awaited_readings.size() == 0) begin
               $display("%0t: result beat with no reading awaited, status %0d",
                        $time, rsp_status);
               faults++;
            end else begin
               want = awaited_readings.pop_front();
               if (rsp_flow_q8 !== want.flow) begin
                  $display("%0t: flow_q8 expected %0d got %0d", $time, want.flow, rsp_flow_q8);
                  faults++;
               end
               if (rsp_temperature_q8 !== want.temp) begin
                  $display("%0t: temperature_q8 expected %0d got %0d",
                           $time, want.temp, rsp_temperature_q8);
                  faults++;
               end
               if (rsp_flag_word !== want.flags) begin
                  $display("%0t: flag_word expected %h got %h", $time, want.flags, rsp_flag_word);
                  faults++;
               end
               if (rsp_status !== want.code) begin
                  $display("%0t: status expected %0d got %0d", $time, want.code, rsp_status);
                  faults++;
               end
               if (rsp_bad_word_index !== want.word) begin
                  $display("%0t: bad_word_index expected %0d got %0d",
                           $time, want.word, rsp_bad_word_index);
                  faults++;
               end
            end
         end
      end
      mismatch_count <= faults;
      readings_due   <= awaited_readings.size();
   end

endmodule

// ----- verif/tb.sv -----
`timescale 1ns / 100ps

module tb;
   import fsfc_pkg::*;

   localparam int          CYCLE_LIMIT   = 1000000;
   localparam int          SETTLE_CYCLES = 2 * (16 + FRACTION_BITS_DEFAULT) + 24;
   localparam logic [1:0]  REG_SPARE     = 2'd3;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_stall;
   logic [7:0]                 req_data_byte = 8'd0;
   logic                       req_frame_start = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_stall = 1'b0;
   logic signed [FLOW_W-1:0]   rsp_flow_q8;
   logic signed [TEMP_W-1:0]   rsp_temperature_q8;
   logic [FLAG_W-1:0]          rsp_flag_word;
   logic [1:0]                 rsp_status;
   logic [INDEX_W-1:0]         rsp_bad_word_index;
   logic                       csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]     csr_index = '0;
   logic [CSR_DATA_W-1:0]      csr_write_data = '0;

   int          mismatches;
   int          readings_due;
   int          cycle_count = 0;
   int          sent_beats = 0;
   int          send_gap_pct = 26;
   int          recv_stall_pct = 85;
   logic [1:0]  cur_words = WORDS_RESET;

   flow_sensor_frame_checker_unit dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_flow_q8        (rsp_flow_q8),
      .rsp_temperature_q8 (rsp_temperature_q8),
      .rsp_flag_word      (rsp_flag_word),
      .rsp_status         (rsp_status),
      .rsp_bad_word_index (rsp_bad_word_index),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   fsfc_reading_checker readings (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_flow_q8        (rsp_flow_q8),
      .rsp_temperature_q8 (rsp_temperature_q8),
      .rsp_flag_word      (rsp_flag_word),
      .rsp_status         (rsp_status),
      .rsp_bad_word_index (rsp_bad_word_index),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data),
      .mismatch_count     (mismatches),
      .readings_due       (readings_due)
   );

   always #2 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end
   end

   // receiver back-pressure
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // one byte beat, held until taken
   task automatic put_beat(input logic [7:0] b, input logic s);
      while ($urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_byte   <= b;
      req_frame_start <= s;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sent_beats++;
   endtask

   // frame of nw words with their check bytes, one word spoilt if asked, cut short at cut bytes
   task automatic send_frame(input logic [15:0] w0, input logic [15:0] w1, input logic [15:0] w2,
                             input int nw, input int bad, input int cut);
      logic [7:0]  frame [9];
      logic [15:0] v;
      for (int i = 0; i < nw; i++) begin
         v = (i == 0) ? w0 : (i == 1) ? w1 : w2;
         frame[3*i]     = v[15:8];
         frame[3*i + 1] = v[7:0];
         frame[3*i + 2] = crc8_byte(crc8_byte(CRC_INIT, v[15:8]), v[7:0])
                          ^ ((i == bad) ? 8'($urandom_range(255, 1)) : 8'h00);
      end
      for (int i = 0; i < cut; i++) begin
         put_beat(frame[i], i == 0);
      end
   endtask

   // mostly well-formed frames, some spoilt, cut short, wrong length or plain noise
   task automatic send_random_frame();
      int          pick;
      int          nw;
      int          bad;
      int          cut;
      logic [15:0] w [3];
      pick  = $urandom_range(99);
      if (pick < 8) begin
         repeat ($urandom_range(6, 1)) put_beat(8'($urandom), $urandom_range(7) == 0);
      end else begin
         nw  = (pick < 90) ? ((cur_words == 2'd0) ? 1 : int'(cur_words)) : $urandom_range(3, 1);
         bad = ($urandom_range(99) < 15) ? $urandom_range(nw - 1, 0) : -1;
         cut = ($urandom_range(99) < 6) ? $urandom_range(nw * 3 - 1, 1) : nw * 3;
         for (int i = 0; i < 3; i++) begin
            case ($urandom_range(19))
               0:       w[i] = 16'h0000;
               1:       w[i] = 16'hFFFF;
               2:       w[i] = 16'h8000;
               3:       w[i] = 16'h7FFF;
               default: w[i] = 16'($urandom);
            endcase
         end
         send_frame(w[0], w[1], w[2], nw, bad, cut);
      end
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
   endtask

   // wait for every awaited reading, then let the divider run dry
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (readings_due != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      int          goal;
      logic [15:0] scale_set;
      logic        meas_set;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // measurement off after reset: one not-measuring reading, then silence
      put_beat(8'hA5, 1'b1);
      put_beat(8'h00, 1'b0);
      settle();
      write_reg(REG_SCALE_DIVISOR, 16'd1);
      write_reg(REG_FRAME_WORD_COUNT, 16'd3);
      write_reg(REG_MEASURING_ENABLED, 16'd1);

      // full-scale flow, temperature and flags
      send_frame(16'h8000, 16'h7FFF, 16'hFFFF, 3, -1, 9);
      // stray byte after a finished frame
      put_beat(8'hFF, 1'b0);
      // unfinished frame dropped by a new start, then a bad check on the temperature word
      send_frame(16'h1234, 16'h0000, 16'h0000, 1, -1, 2);
      send_frame(16'h7FFF, 16'h8000, 16'h0000, 2, 1, 6);
      put_beat(8'h00, 1'b0);
      // bad check on the flow word
      send_frame(16'h0000, 16'h0000, 16'h0000, 1, 0, 3);
      settle();

      // random phases over several register settings and three idling modes
      for (int phase = 0; phase < 9; phase++) begin
         case (phase)
            0:       begin scale_set = 16'hFFFF; cur_words = 2'd1; meas_set = 1'b1; end
            1:       begin scale_set = 16'd0;    cur_words = 2'd2; meas_set = 1'b1; end
            2:       begin scale_set = 16'd200;  cur_words = 2'd0; meas_set = 1'b1; end
            3:       begin scale_set = 16'($urandom_range(65535, 1)); cur_words = 2'd3;
                           meas_set = 1'b0; end
            4:       begin scale_set = 16'd1;    cur_words = 2'd3; meas_set = 1'b1; end
            5:       begin scale_set = 16'($urandom_range(65535, 1)); cur_words = 2'd2;
                           meas_set = 1'b1; end
            6:       begin scale_set = SCALE_RESET; cur_words = 2'd1; meas_set = 1'b1; end
            7:       begin scale_set = 16'($urandom_range(65535, 1)); cur_words = 2'd0;
                           meas_set = 1'b1; end
            default: begin scale_set = 16'($urandom_range(65535, 1)); cur_words = 2'd3;
                           meas_set = 1'b1; end
         endcase
         send_gap_pct   = (phase < 3) ? 26 : (phase < 6) ? 85 : 0;
         recv_stall_pct = (phase < 3) ? 85 : (phase < 6) ? 26 : 0;
         // unused upper data bits carry noise
         write_reg(REG_SCALE_DIVISOR, scale_set);
         write_reg(REG_FRAME_WORD_COUNT, (16'($urandom) & 16'hFFFC) | {14'd0, cur_words});
         write_reg(REG_MEASURING_ENABLED, (16'($urandom) & 16'hFFFE) | {15'd0, meas_set});
         if (phase == 2) begin
            write_reg(REG_SPARE, 16'($urandom));
         end
         goal = sent_beats + (meas_set ? 200 : 50);
         while (sent_beats < goal) begin
            send_random_frame();
         end
         settle();
      end

      if (mismatches == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ----- files.f -----
+incdir+rtl/core
rtl/core/fsfc_pkg.sv
rtl/core/fsfc_div.sv
rtl/core/fsfc_ctrl.sv
rtl/core/fsfc_dp.sv
rtl/core/flow_sensor_frame_checker_unit.sv
rtl/core/fsfc_checker.sv
verif/fsfc_reading_checker.sv
verif/tb.sv
